// File: src/mcpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator package
// Shared codes, control types and the octant mapping table.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  // Input item function codes.
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_e;

  // Kind of work handed from the front end to the back end.
  typedef enum logic {
    CMD_IDLE   = 1'b0,
    CMD_POINTS = 1'b1
  } cmd_kind_e;

  // Control group that travels with each queued command.
  typedef struct packed {
    cmd_kind_e kind;
    logic      fin;
  } cmd_ctrl_t;

  // How one octant is formed from the (x, y) offsets.
  typedef struct packed {
    logic swap;
    logic neg_x;
    logic neg_y;
  } oct_map_t;

  localparam int unsigned OCT_W    = 3;
  localparam logic [OCT_W-1:0] OCT_FIRST = 3'd0;
  localparam logic [OCT_W-1:0] OCT_LAST  = 3'd7;

  // Decision term constants.
  localparam int DEC_INIT_BIAS = 1;
  localparam int DEC_ADD_E     = 3;
  localparam int DEC_ADD_SE    = 5;

  // Octant order: (x,y) (y,x) (-y,x) (-x,y) (-x,-y) (-y,-x) (x,-y) (y,-x).
  function automatic oct_map_t oct_map(input logic [OCT_W-1:0] oct);
    oct_map_t m;
    unique case (oct)
      3'd0:    m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
      3'd1:    m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
      3'd2:    m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
      3'd3:    m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
      3'd4:    m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
      3'd5:    m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
      3'd6:    m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
      default: m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
    endcase
    return m;
  endfunction

endpackage

// File: src/midpoint_circle_point_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle point generator
// Rasterises circles by the midpoint method with eight-way symmetry.
// ----------------------------------------------------------------------------
// A load beat (func 0) stores a centre and radius and gives no result. A step
// beat (func 1) yields eight result beats, one per octant, or a single result
// with no point when no circle is active. Results leave at one beat per clock
// cycle, while the receiver is ready, from the back end's single output
// register; loads take no output time. The front end updates the decision
// term as a step is accepted and a two-entry command queue lets it accept
// further beats while earlier points are still leaving. The first result of
// a step passes through the command queue, the back end's command registers
// and its output register.
module midpoint_circle_point_generator_unit import mcpg_pkg::*; #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS:0]    point_x_o,
  output logic signed [COORD_BITS:0]    point_y_o,
  output logic        [OCT_W-1:0]       octant_o,
  output logic                          point_valid_o,
  output logic                          last_of_step_o,
  output logic                          circle_done_o
);

  localparam int unsigned CTRL_W = $bits(cmd_ctrl_t);
  localparam int unsigned OFF_W  = RADIUS_BITS + 1;
  localparam int unsigned Y_W    = RADIUS_BITS + 2;
  localparam int unsigned CMD_W  = CTRL_W + 2 * COORD_BITS + OFF_W + Y_W;

  logic                         f_valid, f_ready, b_valid, b_ready;
  cmd_ctrl_t                    f_ctrl, b_ctrl;
  logic signed [COORD_BITS-1:0] f_cx, f_cy, b_cx, b_cy;
  logic        [OFF_W-1:0]      f_x, b_x;
  logic signed [Y_W-1:0]        f_y, b_y;
  logic        [CMD_W-1:0]      wr_data, rd_data;

  // Front end: circle state and classification.
  mcpg_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_ctrl_o  (f_ctrl),
    .cmd_cx_o    (f_cx),
    .cmd_cy_o    (f_cy),
    .cmd_x_o     (f_x),
    .cmd_y_o     (f_y)
  );

  // Command queue between the two halves.
  assign wr_data = {f_ctrl, f_cx, f_cy, f_x, f_y};
  assign {b_ctrl, b_cx, b_cy, b_x, b_y} = rd_data;

  mcpg_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (wr_data),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (rd_data)
  );

  // Back end: octant expansion and result register.
  mcpg_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (b_valid),
    .cmd_ready_o    (b_ready),
    .cmd_ctrl_i     (b_ctrl),
    .cmd_cx_i       (b_cx),
    .cmd_cy_i       (b_cy),
    .cmd_x_i        (b_x),
    .cmd_y_i        (b_y),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .octant_o       (octant_o),
    .point_valid_o  (point_valid_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

endmodule

// File: src/mcpg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle front end
// Accepts input beats, holds the circle state and advances the decision term.
// Each step beat is turned into one command for the back end.
// ----------------------------------------------------------------------------
module mcpg_front import mcpg_pkg::*; #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output cmd_ctrl_t                     cmd_ctrl_o,
  output logic signed [COORD_BITS-1:0]  cmd_cx_o,
  output logic signed [COORD_BITS-1:0]  cmd_cy_o,
  output logic        [RADIUS_BITS:0]   cmd_x_o,
  output logic signed [RADIUS_BITS+1:0] cmd_y_o
);

  localparam int unsigned OFF_W = RADIUS_BITS + 1;
  localparam int unsigned Y_W   = RADIUS_BITS + 2;
  localparam int unsigned DEC_W = RADIUS_BITS + 4;

  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic        [OFF_W-1:0]      x_q, x_d;
  logic signed [Y_W-1:0]        y_q, y_d;
  logic signed [DEC_W-1:0]      dec_q, dec_d, dec_init;
  logic                         active_q;
  logic                         accept, is_step, fin;
  logic        [DEC_W-1:0]      x_ext, y_ext, diff;

  // Loads never need the queue, but keep ready simple and payload independent.
  assign in_ready_o  = cmd_ready_i;
  assign is_step     = (func_i == FUNC_STEP);
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = in_valid_i && is_step;

  // Decision update on the old offsets.
  assign x_ext = {{(DEC_W-OFF_W){1'b0}}, x_q};
  assign y_ext = {{(DEC_W-Y_W){y_q[Y_W-1]}}, y_q};
  assign diff  = x_ext - y_ext;

  always_comb begin
    x_d = x_q + OFF_W'(1);
    if (dec_q[DEC_W-1]) begin
      dec_d = dec_q + $signed({x_ext[DEC_W-2:0], 1'b0}) + DEC_W'(DEC_ADD_E);
      y_d   = y_q;
    end else begin
      dec_d = dec_q + $signed({diff[DEC_W-2:0], 1'b0}) + DEC_W'(DEC_ADD_SE);
      y_d   = y_q - Y_W'(1);
    end
  end

  assign fin      = $signed({1'b0, x_d}) > y_d;
  assign dec_init = DEC_W'(DEC_INIT_BIAS) - {{(DEC_W-RADIUS_BITS){1'b0}}, radius_i};

  // Command contents: the offsets before this step.
  assign cmd_ctrl_o.kind = active_q ? CMD_POINTS : CMD_IDLE;
  assign cmd_ctrl_o.fin  = active_q ? fin : 1'b1;
  assign cmd_cx_o        = cx_q;
  assign cmd_cy_o        = cy_q;
  assign cmd_x_o         = x_q;
  assign cmd_y_o         = y_q;

  // Circle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        cx_q     <= center_x_i;
        cy_q     <= center_y_i;
        x_q      <= '0;
        y_q      <= $signed({2'b00, radius_i});
        dec_q    <= dec_init;
        active_q <= 1'b1;
      end else if (active_q) begin
        x_q   <= x_d;
        y_q   <= y_d;
        dec_q <= dec_d;
        if (fin) begin
          active_q <= 1'b0;
        end
      end
    end
  end

endmodule

// File: src/mcpg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mcpg_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_push_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue count did not grow on a lone push");
`endif

endmodule

// File: src/mcpg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle back end
// Expands each command into its eight octant points, one result beat a cycle
// unless stalled, or a single idle result, via a registered output stage.
// ----------------------------------------------------------------------------
module mcpg_back import mcpg_pkg::*; #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  cmd_ctrl_t                     cmd_ctrl_i,
  input  logic signed [COORD_BITS-1:0]  cmd_cx_i,
  input  logic signed [COORD_BITS-1:0]  cmd_cy_i,
  input  logic        [RADIUS_BITS:0]   cmd_x_i,
  input  logic signed [RADIUS_BITS+1:0] cmd_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS:0]    point_x_o,
  output logic signed [COORD_BITS:0]    point_y_o,
  output logic        [OCT_W-1:0]       octant_o,
  output logic                          point_valid_o,
  output logic                          last_of_step_o,
  output logic                          circle_done_o
);

  localparam int unsigned OFF_W = RADIUS_BITS + 1;
  localparam int unsigned Y_W   = RADIUS_BITS + 2;
  localparam int unsigned PT_W  = COORD_BITS + 1;
  localparam int unsigned SUM_W = ((COORD_BITS > Y_W) ? COORD_BITS : Y_W) + 1;

  // Command being expanded.
  logic                         busy_q;
  cmd_ctrl_t                    ctrl_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic        [OFF_W-1:0]      x_q;
  logic signed [Y_W-1:0]        y_q;
  logic        [OCT_W-1:0]      oct_q;

  // Output register.
  logic                         out_valid_q;
  logic signed [PT_W-1:0]       px_q, py_q;
  logic        [OCT_W-1:0]      oct_out_q;
  logic                         pvalid_q, last_q, done_q;

  logic                         adv, last_now, take;
  oct_map_t                     map;
  logic signed [SUM_W-1:0]      cx_e, cy_e, x_e, y_e, mag_x, mag_y, off_x, off_y;
  logic signed [SUM_W-1:0]      sum_x, sum_y;

  assign adv         = busy_q && (!out_valid_q || out_ready_i);
  assign last_now    = (ctrl_q.kind == CMD_IDLE) || (oct_q == OCT_LAST);
  assign cmd_ready_o = !busy_q || (adv && last_now);
  assign take        = cmd_valid_i && cmd_ready_o;

  // Point of the current octant.
  assign map   = oct_map(oct_q);
  assign cx_e  = {{(SUM_W-COORD_BITS){cx_q[COORD_BITS-1]}}, cx_q};
  assign cy_e  = {{(SUM_W-COORD_BITS){cy_q[COORD_BITS-1]}}, cy_q};
  assign x_e   = $signed({{(SUM_W-OFF_W){1'b0}}, x_q});
  assign y_e   = {{(SUM_W-Y_W){y_q[Y_W-1]}}, y_q};
  assign mag_x = map.swap ? y_e : x_e;
  assign mag_y = map.swap ? x_e : y_e;
  assign off_x = map.neg_x ? -mag_x : mag_x;
  assign off_y = map.neg_y ? -mag_y : mag_y;
  assign sum_x = cx_e + off_x;
  assign sum_y = cy_e + off_y;

  // Control: command occupancy, octant count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      oct_q       <= OCT_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        busy_q <= 1'b1;
        oct_q  <= OCT_FIRST;
      end else if (adv) begin
        if (last_now) begin
          busy_q <= 1'b0;
          oct_q  <= OCT_FIRST;
        end else begin
          oct_q <= oct_q + OCT_W'(1);
        end
      end
    end
  end

  // Command payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ctrl_q <= cmd_ctrl_i;
      cx_q   <= cmd_cx_i;
      cy_q   <= cmd_cy_i;
      x_q    <= cmd_x_i;
      y_q    <= cmd_y_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (ctrl_q.kind == CMD_IDLE) begin
        px_q      <= '0;
        py_q      <= '0;
        oct_out_q <= OCT_FIRST;
        pvalid_q  <= 1'b0;
        last_q    <= 1'b1;
        done_q    <= 1'b1;
      end else begin
        px_q      <= sum_x[PT_W-1:0];
        py_q      <= sum_y[PT_W-1:0];
        oct_out_q <= oct_q;
        pvalid_q  <= 1'b1;
        last_q    <= last_now;
        done_q    <= last_now && ctrl_q.fin;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign octant_o       = oct_out_q;
  assign point_valid_o  = pvalid_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

`ifndef SYNTHESIS
  a_idle_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> last_of_step_o && circle_done_o)
    else $error("idle result must be last and done");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && circle_done_o |-> last_of_step_o)
    else $error("done flagged on a beat that is not last");

  a_last_point_octant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && point_valid_o && last_of_step_o |-> octant_o == OCT_LAST)
    else $error("last point of a step is not the final octant");

  a_idle_counter_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> oct_q == OCT_FIRST)
    else $error("octant counter not cleared while no command is held");
`endif

endmodule

// File: tb/tb_midpoint_circle_point_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle point generator testbench
// Drives load and step beats with random gaps and output stalls, predicts
// the eight symmetric points of each step on a circle, checks every result in order.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_point_generator_unit;
  import mcpg_pkg::*;

  localparam int unsigned CB = 12;
  localparam int unsigned RB = 10;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 16;

  // One expected result beat.
  typedef struct packed {
    logic signed [CB:0]    px;
    logic signed [CB:0]    py;
    logic [OCT_W-1:0]      oct;
    logic                  pvalid;
    logic                  last;
    logic                  done;
  } point_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 func_i;
  logic signed [CB-1:0] center_x_i;
  logic signed [CB-1:0] center_y_i;
  logic [RB-1:0]        radius_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [CB:0]   point_x_o;
  logic signed [CB:0]   point_y_o;
  logic [OCT_W-1:0]     octant_o;
  logic                 point_valid_o;
  logic                 last_of_step_o;
  logic                 circle_done_o;

  // Predicted circle state.
  logic signed [CB-1:0] ctr_x;
  logic signed [CB-1:0] ctr_y;
  int                   off_x;
  logic signed [RB+1:0] off_y;
  logic signed [RB+3:0] dterm;
  logic                 tracing;

  point_beat_t pending_points[$];
  bit          mismatch_seen;
  int          beats_sent;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          cycle_count;

  midpoint_circle_point_generator_unit #(
    .COORD_BITS (CB),
    .RADIUS_BITS(RB)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .octant_o      (octant_o),
    .point_valid_o (point_valid_o),
    .last_of_step_o(last_of_step_o),
    .circle_done_o (circle_done_o)
  );

  always #5 clk_i = ~clk_i;

  // Run time guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("midpoint_circle_point_generator_unit: mismatch");
      $finish;
    end
  end

  // Works out the result beats caused by one accepted input beat.
  task automatic trace_circle_beat(input func_e f, input logic signed [CB-1:0] cx,
                                   input logic signed [CB-1:0] cy,
                                   input logic [RB-1:0] r);
    int          x;
    int          y;
    int          nd;
    int          dx[8];
    int          dy[8];
    logic        fin;
    point_beat_t b;
    if (f == FUNC_LOAD) begin
      ctr_x   = cx;
      ctr_y   = cy;
      off_x   = 0;
      off_y   = (RB+2)'(r);
      dterm   = (RB+4)'(DEC_INIT_BIAS - int'(r));
      tracing = 1'b1;
    end else if (!tracing) begin
      // A step with no circle gives a single empty, finished beat.
      b = '{px: '0, py: '0, oct: OCT_FIRST, pvalid: 1'b0, last: 1'b1, done: 1'b1};
      pending_points.push_back(b);
    end else begin
      x = off_x;
      y = int'(off_y);
      dx = '{x, y, -y, -x, -x, -y, x, y};
      dy = '{y, x, x, y, -y, -x, -y, -x};
      // The decision update uses the offsets from before the step.
      if (dterm < 0) begin
        nd = int'(dterm) + 2 * x + DEC_ADD_E;
      end else begin
        nd = int'(dterm) + 2 * (x - y) + DEC_ADD_SE;
        off_y = (RB+2)'(off_y - 1);
      end
      dterm = (RB+4)'(nd);
      off_x = x + 1;
      fin = off_x > int'(off_y);
      if (fin) tracing = 1'b0;
      for (int k = 0; k < 8; k++) begin
        b.px     = (CB+1)'(int'(ctr_x) + dx[k]);
        b.py     = (CB+1)'(int'(ctr_y) + dy[k]);
        b.oct    = OCT_W'(k);
        b.pvalid = 1'b1;
        b.last   = (b.oct == OCT_LAST);
        b.done   = b.last && fin;
        pending_points.push_back(b);
      end
    end
  endtask

  // Presents one input beat and waits until it is accepted. Valid is left
  // high on return so that a following beat can go out back to back.
  task automatic send_beat(input func_e f, input logic signed [CB-1:0] cx,
                           input logic signed [CB-1:0] cy, input logic [RB-1:0] r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    trace_circle_beat(f, cx, cy, r);
    beats_sent++;
  endtask

  // Step beat with random, ignored payload.
  task automatic send_step();
    send_beat(FUNC_STEP, CB'($urandom), CB'($urandom), RB'($urandom));
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    point_beat_t exp_b;
    point_beat_t got_b;
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_b = '{px: point_x_o, py: point_y_o, oct: octant_o, pvalid: point_valid_o,
                last: last_of_step_o, done: circle_done_o};
      if (pending_points.size() == 0) begin
        mismatch_seen = 1'b1;
        $display("%0t: result beat with none expected: x=%0d y=%0d oct=%0d v=%b l=%b d=%b",
                 $time, got_b.px, got_b.py, got_b.oct, got_b.pvalid, got_b.last,
                 got_b.done);
      end else begin
        exp_b = pending_points.pop_front();
        if (got_b !== exp_b) begin
          mismatch_seen = 1'b1;
          $display("%0t: expected x=%0d y=%0d oct=%0d v=%b l=%b d=%b", $time, exp_b.px,
                   exp_b.py, exp_b.oct, exp_b.pvalid, exp_b.last, exp_b.done);
          $display("%0t: actual   x=%0d y=%0d oct=%0d v=%b l=%b d=%b", $time, got_b.px,
                   got_b.py, got_b.oct, got_b.pvalid, got_b.last, got_b.done);
        end
      end
    end
  end

  // Steps on a block with no circle loaded.
  task automatic test_step_while_idle();
    send_step();
    send_step();
  endtask

  // A zero radius emits the centre eight times, then the block is idle.
  task automatic test_zero_radius();
    send_beat(FUNC_LOAD, '0, '0, '0);
    send_step();
    send_step();
  endtask

  // Centre and radius extremes, and a load that cuts a circle short.
  task automatic test_extremes();
    send_beat(FUNC_LOAD, CB'(-2048), CB'(-2048), RB'(1023));
    repeat (3) send_step();
    send_beat(FUNC_LOAD, CB'(2047), CB'(2047), RB'(1023));
    repeat (3) send_step();
    send_beat(FUNC_LOAD, CB'(-2048), CB'(2047), RB'(1));
    send_step();
    send_beat(FUNC_LOAD, CB'(2047), CB'(-2048), '0);
    send_step();
  endtask

  // A small circle traced to the end, then one step too many.
  task automatic test_small_circle();
    send_beat(FUNC_LOAD, CB'(5), CB'(-7), RB'(3));
    while (tracing) send_step();
    send_step();
  endtask

  // Mostly whole circles with random content, some cut short, plus stray beats.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_beats);
    int target;
    int cap;
    int steps;
    logic [RB-1:0] r;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      if ($urandom_range(99) < 80) begin
        r = ($urandom_range(9) == 0) ? RB'($urandom_range(1023)) : RB'($urandom_range(40));
        cap = (r <= 40) ? 1000 : $urandom_range(4, 24);
        if ($urandom_range(99) < 15) cap = $urandom_range(0, 5);
        send_beat(FUNC_LOAD, CB'($urandom), CB'($urandom), r);
        steps = 0;
        while (tracing && steps < cap) begin
          send_step();
          steps++;
        end
        if ($urandom_range(1) == 1) send_step();
      end else if ($urandom_range(1) == 1) begin
        send_step();
      end else begin
        send_beat(FUNC_LOAD, CB'($urandom), CB'($urandom), RB'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    func_i             = FUNC_LOAD;
    center_x_i         = '0;
    center_y_i         = '0;
    radius_i           = '0;
    out_ready_i        = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatch_seen      = 1'b0;
    beats_sent         = 0;
    cycle_count        = 0;
    tracing            = 1'b0;
    ctr_x              = '0;
    ctr_y              = '0;
    off_x              = 0;
    off_y              = '0;
    dterm              = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_step_while_idle();
    test_zero_radius();
    test_extremes();
    test_small_circle();
    test_random_traffic(0, 0, 120);
    test_random_traffic(81, 0, 120);
    test_random_traffic(0, 81, 120);
    test_random_traffic(7, 7, 120);

    // Drain the remaining points, then give stray beats time to show up.
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (!mismatch_seen && pending_points.size() == 0) begin
      $display("midpoint_circle_point_generator_unit: match");
    end else begin
      $display("midpoint_circle_point_generator_unit: mismatch");
    end
    $finish;
  end

endmodule
